[src/lav_pkg.sv]
// ----------------------------------------------------------------------------
// Look-at view matrix package
// Shared widths, types and constants for the view matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

  localparam int COORD_W = 32;
  localparam int ROT_FRAC = 30;
  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int ROW_W = 2;

  localparam logic [ROW_W-1:0] ROW_RIGHT = 2'd0;
  localparam logic [ROW_W-1:0] ROW_UP = 2'd1;
  localparam logic [ROW_W-1:0] ROW_LOOK = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [33:0] vec_t;
  typedef logic [63:0] mag_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } rot3_t;

  typedef struct packed {
    logic valid;
    logic ok;
  } nrm_stat_t;

endpackage

[src/look_at_view_matrix.sv]
// ----------------------------------------------------------------------------
// Look-at view matrix
// Builds the three rows of a camera view matrix from eye, target and up.
// ----------------------------------------------------------------------------
// Usage: drive the nine Q16.16 coordinates and pulse start while busy is low.
// A request is taken at that edge. Three result rows follow on consecutive
// cycles, each marked by strobe for one cycle: right, true up, negated look,
// with last_row set on the third. degenerate is set on all three rows when
// the look, up or right vector is zero, and the numeric fields are zero.
// Each normalizer has a range scaling stage, a sum-of-squares stage, a
// 32-step square root and a 32-step division. The look and up normalizers
// run side by side; the cross product and the right normalizer follow, and
// then the true up cross product, with the right, look and eye values staged
// beside it, row capture, row selection and the translation output register.
// Requests overlap in the pipeline; busy is raised after each request so
// that the one-row-per-cycle result channel is never overrun.
// The receiver cannot stall; every row must be taken when strobe is high.
// Reset clears all valid bits; requests in flight are dropped.
// ----------------------------------------------------------------------------
module look_at_view_matrix #(
  parameter int COORD_FRAC_BITS = lav_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  lav_pkg::coord_t         eye_x,
  input  lav_pkg::coord_t         eye_y,
  input  lav_pkg::coord_t         eye_z,
  input  lav_pkg::coord_t         target_x,
  input  lav_pkg::coord_t         target_y,
  input  lav_pkg::coord_t         target_z,
  input  lav_pkg::coord_t         up_x,
  input  lav_pkg::coord_t         up_y,
  input  lav_pkg::coord_t         up_z,
  output logic                    strobe,
  output logic [1:0]              row_index,
  output logic signed [31:0]      col_x,
  output logic signed [31:0]      col_y,
  output logic signed [31:0]      col_z,
  output logic signed [31:0]      translation,
  output logic                    last_row,
  output logic                    degenerate
);
  import lav_pkg::*;

  logic [1:0] gap;
  logic acc;

  assign acc = start && !busy;
  assign busy = (gap != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= 2'd0;
    end else if (acc) begin
      gap <= 2'd2;
    end else if (gap != 2'd0) begin
      gap <= gap - 2'd1;
    end
  end

  nrm_stat_t ls, us, rs;
  rot3_t lu, uu, ru;

  lav_normalize u_look (
    .clk(clk), .rst(rst), .in_valid(acc),
    .vx(64'(target_x) - 64'(eye_x)), .vy(64'(target_y) - 64'(eye_y)),
    .vz(64'(target_z) - 64'(eye_z)), .stat(ls), .u(lu)
  );
  lav_normalize u_up (
    .clk(clk), .rst(rst), .in_valid(acc),
    .vx(64'(up_x)), .vy(64'(up_y)), .vz(64'(up_z)), .stat(us), .u(uu)
  );

  localparam int NDEPTH = 66;
  localparam int XDEPTH = 2;
  localparam int DLY = NDEPTH + NDEPTH + XDEPTH;

  coord_t ed [DLY][3];
  always_ff @(posedge clk) begin
    ed[0] <= '{eye_x, eye_y, eye_z};
    for (int i = 1; i < DLY; i++) begin
      ed[i] <= ed[i-1];
    end
  end

  logic xv;
  logic signed [63:0] rx, ry, rz;
  lav_cross u_lxu (
    .clk(clk), .rst(rst), .in_valid(ls.valid), .a(lu), .b(uu),
    .out_valid(xv), .cx(rx), .cy(ry), .cz(rz)
  );

  rot3_t lu_d [NDEPTH + XDEPTH];
  logic ok_d [NDEPTH + XDEPTH];
  always_ff @(posedge clk) begin
    lu_d[0] <= lu;
    ok_d[0] <= ls.ok && us.ok;
    for (int i = 1; i < NDEPTH + XDEPTH; i++) begin
      lu_d[i] <= lu_d[i-1];
      ok_d[i] <= ok_d[i-1];
    end
  end

  lav_normalize u_right (
    .clk(clk), .rst(rst), .in_valid(xv),
    .vx(rx), .vy(ry), .vz(rz), .stat(rs), .u(ru)
  );

  lav_rows #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_rows (
    .clk(clk), .rst(rst), .in_valid(rs.valid),
    .ok(rs.ok && ok_d[NDEPTH + XDEPTH - 1]), .ru(ru), .lu(lu_d[NDEPTH + XDEPTH - 1]),
    .ex(ed[DLY-1][0]), .ey(ed[DLY-1][1]), .ez(ed[DLY-1][2]),
    .strobe(strobe), .row_index(row_index),
    .col_x(col_x), .col_y(col_y), .col_z(col_z), .translation(translation),
    .last_row(last_row), .degenerate(degenerate)
  );

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    acc |=> busy ##1 busy)
    else $error("request spacing broken");
  a_degenerate_zeros: assert property (@(posedge clk) disable iff (rst)
    strobe && degenerate |-> col_x == 0 && col_y == 0 && translation == 0)
    else $error("degenerate row not cleared");
  a_up_row_after_right: assert property (@(posedge clk) disable iff (rst)
    strobe && row_index == ROW_RIGHT |=> strobe && row_index == ROW_UP)
    else $error("rows out of order");
endmodule

[src/lav_normalize.sv]
// ----------------------------------------------------------------------------
// Look-at normalizer
// Turns a signed vector into a Q1.30 unit vector: range scaling, a staged
// integer square root and three staged restoring divisions.
// ----------------------------------------------------------------------------
module lav_normalize (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic signed [63:0]  vx,
  input  logic signed [63:0]  vy,
  input  logic signed [63:0]  vz,
  output lav_pkg::nrm_stat_t  stat,
  output lav_pkg::rot3_t      u
);
  import lav_pkg::*;

  localparam int SQ_STEPS = 32;
  localparam int DV_STEPS = 32;

  logic [63:0] ax, ay, az, mx;
  logic [6:0]  lz;
  logic [31:0] sx, sy, sz;

  always_comb begin
    ax = vx[63] ? 64'(-vx) : 64'(vx);
    ay = vy[63] ? 64'(-vy) : 64'(vy);
    az = vz[63] ? 64'(-vz) : 64'(vz);
    mx = ax | ay | az;
    lz = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (mx[i]) begin
        lz = 7'(63 - i);
      end
    end
    if (lz <= 7'd32) begin
      sx = 32'(ax >> (7'd33 - lz));
      sy = 32'(ay >> (7'd33 - lz));
      sz = 32'(az >> (7'd33 - lz));
    end else begin
      sx = 32'(ax << (lz - 7'd33));
      sy = 32'(ay << (lz - 7'd33));
      sz = 32'(az << (lz - 7'd33));
    end
  end

  logic        s0_v, s0_ok;
  logic [2:0]  s0_sg;
  logic [31:0] s0_a [3];
  logic        s1_v, s1_ok;
  logic [2:0]  s1_sg;
  logic [31:0] s1_a [3];
  logic [63:0] s1_ss;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
      s1_v <= 1'b0;
    end else begin
      s0_v <= in_valid;
      s1_v <= s0_v;
    end
    s0_ok <= (mx != 64'd0);
    s0_sg <= {vz[63], vy[63], vx[63]};
    s0_a[0] <= sx;
    s0_a[1] <= sy;
    s0_a[2] <= sz;
    s1_ok <= s0_ok;
    s1_sg <= s0_sg;
    s1_a <= s0_a;
    s1_ss <= 64'({32'd0, s0_a[0]} * {32'd0, s0_a[0]})
           + 64'({32'd0, s0_a[1]} * {32'd0, s0_a[1]})
           + 64'({32'd0, s0_a[2]} * {32'd0, s0_a[2]});
  end

  logic        q_v  [SQ_STEPS+1];
  logic        q_ok [SQ_STEPS+1];
  logic [2:0]  q_sg [SQ_STEPS+1];
  logic [31:0] q_a  [SQ_STEPS+1][3];
  logic [63:0] q_x  [SQ_STEPS+1];
  logic [65:0] q_rem [SQ_STEPS+1];
  logic [32:0] q_r  [SQ_STEPS+1];

  always_comb begin
    q_v[0] = s1_v;
    q_ok[0] = s1_ok;
    q_sg[0] = s1_sg;
    q_a[0] = s1_a;
    q_x[0] = s1_ss;
    q_rem[0] = 66'd0;
    q_r[0] = 33'd0;
  end

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
    logic [65:0] rem_sh, trial;
    always_comb begin
      rem_sh = {q_rem[g][63:0], q_x[g][63:62]};
      trial = {31'd0, q_r[g], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        q_v[g+1] <= 1'b0;
      end else begin
        q_v[g+1] <= q_v[g];
      end
      q_ok[g+1] <= q_ok[g];
      q_sg[g+1] <= q_sg[g];
      q_a[g+1] <= q_a[g];
      q_x[g+1] <= {q_x[g][61:0], 2'b00};
      if (rem_sh >= trial) begin
        q_rem[g+1] <= rem_sh - trial;
        q_r[g+1] <= {q_r[g][31:0], 1'b1};
      end else begin
        q_rem[g+1] <= rem_sh;
        q_r[g+1] <= {q_r[g][31:0], 1'b0};
      end
    end
  end

  logic        d_v  [DV_STEPS+1];
  logic        d_ok [DV_STEPS+1];
  logic [2:0]  d_sg [DV_STEPS+1];
  logic [31:0] d_n  [DV_STEPS+1];
  logic [63:0] d_num [DV_STEPS+1][3];
  logic [31:0] d_rem [DV_STEPS+1][3];
  logic [31:0] d_q  [DV_STEPS+1][3];

  always_comb begin
    d_v[0] = q_v[SQ_STEPS];
    d_n[0] = q_r[SQ_STEPS][31:0];
    d_ok[0] = q_ok[SQ_STEPS] && (q_r[SQ_STEPS][31:0] != 32'd0);
    d_sg[0] = q_sg[SQ_STEPS];
    for (int k = 0; k < 3; k++) begin
      d_num[0][k] = {2'd0, q_a[SQ_STEPS][k], 30'd0} + {33'd0, q_r[SQ_STEPS][31:1]};
      d_rem[0][k] = d_num[0][k][63:32];
      d_q[0][k] = 32'd0;
    end
  end

  for (genvar g = 0; g < DV_STEPS; g++) begin : g_div
    logic [32:0] sh [3];
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        sh[k] = {d_rem[g][k], d_num[g][k][31]};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        d_v[g+1] <= 1'b0;
      end else begin
        d_v[g+1] <= d_v[g];
      end
      d_ok[g+1] <= d_ok[g];
      d_sg[g+1] <= d_sg[g];
      d_n[g+1] <= d_n[g];
      for (int k = 0; k < 3; k++) begin
        d_num[g+1][k] <= {d_num[g][k][62:0], 1'b0};
        if (sh[k] >= {1'b0, d_n[g]}) begin
          d_rem[g+1][k] <= 32'(sh[k] - {1'b0, d_n[g]});
          d_q[g+1][k] <= {d_q[g][k][30:0], 1'b1};
        end else begin
          d_rem[g+1][k] <= sh[k][31:0];
          d_q[g+1][k] <= {d_q[g][k][30:0], 1'b0};
        end
      end
    end
  end

  logic [31:0] qc [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qc[k] = (d_q[DV_STEPS][k] > 32'h4000_0000) ? 32'h4000_0000 : d_q[DV_STEPS][k];
    end
    stat.valid = d_v[DV_STEPS];
    stat.ok = d_ok[DV_STEPS];
    u.x = d_sg[DV_STEPS][0] ? -$signed(qc[0]) : $signed(qc[0]);
    u.y = d_sg[DV_STEPS][1] ? -$signed(qc[1]) : $signed(qc[1]);
    u.z = d_sg[DV_STEPS][2] ? -$signed(qc[2]) : $signed(qc[2]);
  end

  a_ok_needs_valid_path: assert property (@(posedge clk) disable iff (rst)
    q_v[SQ_STEPS] |=> ##(DV_STEPS-1) stat.valid)
    else $error("normalizer lost a request");
  a_unit_bounded: assert property (@(posedge clk) disable iff (rst)
    stat.valid && stat.ok |-> qc[0] <= 32'h4000_0000 && qc[1] <= 32'h4000_0000)
    else $error("unit term out of range");
  a_zero_not_ok: assert property (@(posedge clk) disable iff (rst)
    in_valid && vx == 0 && vy == 0 && vz == 0 |=> !s0_ok)
    else $error("zero vector flagged usable");
endmodule

[src/lav_cross.sv]
// ----------------------------------------------------------------------------
// Look-at cross product
// Registered Q1.30 cross product with a two-stage multiply and subtract.
// ----------------------------------------------------------------------------
module lav_cross (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  lav_pkg::rot3_t a,
  input  lav_pkg::rot3_t b,
  output logic           out_valid,
  output logic signed [63:0] cx,
  output logic signed [63:0] cy,
  output logic signed [63:0] cz
);
  import lav_pkg::*;

  logic v1;
  logic signed [63:0] p [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      out_valid <= v1;
    end
    p[0] <= a.y * b.z;
    p[1] <= a.z * b.y;
    p[2] <= a.z * b.x;
    p[3] <= a.x * b.z;
    p[4] <= a.x * b.y;
    p[5] <= a.y * b.x;
    cx <= p[0] - p[1];
    cy <= p[2] - p[3];
    cz <= p[4] - p[5];
  end

  a_valid_two: assert property (@(posedge clk) disable iff (rst)
    in_valid |=> ##1 out_valid)
    else $error("cross product lost a request");
endmodule

[src/lav_rows.sv]
// ----------------------------------------------------------------------------
// Look-at row serializer
// Builds true up, computes translations and emits one row per cycle.
// ----------------------------------------------------------------------------
module lav_rows #(
  parameter int COORD_FRAC_BITS = lav_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                ok,
  input  lav_pkg::rot3_t      ru,
  input  lav_pkg::rot3_t      lu,
  input  lav_pkg::coord_t     ex,
  input  lav_pkg::coord_t     ey,
  input  lav_pkg::coord_t     ez,
  output logic                strobe,
  output logic [1:0]          row_index,
  output logic signed [31:0]  col_x,
  output logic signed [31:0]  col_y,
  output logic signed [31:0]  col_z,
  output logic signed [31:0]  translation,
  output logic                last_row,
  output logic                degenerate
);
  import lav_pkg::*;

  localparam int TR_SHIFT = (ROT_FRAC + COORD_FRAC_BITS) - COORD_FRAC_BITS;

  logic cv;
  logic signed [63:0] px, py, pz;
  rot3_t ru1, lu1, ru2, lu2, ru3, lu3;
  coord_t e1 [3], e2 [3], e3 [3];
  logic ok1, ok2, ok3, v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    ok1 <= ok; ru1 <= ru; lu1 <= lu; e1 <= '{ex, ey, ez};
    ok2 <= ok1; ru2 <= ru1; lu2 <= lu1; e2 <= e1;
    ok3 <= ok2; ru3 <= ru2; lu3 <= lu2; e3 <= e2;
  end

  lav_cross u_cross (
    .clk(clk), .rst(rst), .in_valid(v1), .a(ru1), .b(lu1),
    .out_valid(cv), .cx(px), .cy(py), .cz(pz)
  );

  function automatic logic signed [31:0] rnd_up(input logic signed [63:0] x);
    logic [63:0] m;
    logic signed [63:0] t;
    m = x[63] ? 64'(-x) : 64'(x);
    m = (m + 64'(1 << (ROT_FRAC - 1))) >> ROT_FRAC;
    t = x[63] ? -$signed(m) : $signed(m);
    if (t > 64'sd1073741824) t = 64'sd1073741824;
    if (t < -64'sd1073741824) t = -64'sd1073741824;
    return t[31:0];
  endfunction

  rot3_t rw [3];
  logic q_v, q_ok;
  coord_t q_e [3];
  logic [1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_v <= 1'b0;
    end else if (cv) begin
      q_v <= 1'b1;
    end else if (cnt == ROW_LOOK) begin
      q_v <= 1'b0;
    end
    if (cv) begin
      q_ok <= ok3;
      q_e <= e3;
      rw[0] <= ru3;
      rw[1] <= '{rnd_up(px), rnd_up(py), rnd_up(pz)};
      rw[2] <= '{-lu3.x, -lu3.y, -lu3.z};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cv) begin
      cnt <= ROW_RIGHT;
    end else if (q_v && cnt != ROW_LOOK) begin
      cnt <= cnt + 2'd1;
    end
  end

  logic t_v, t_ok;
  logic [1:0] t_idx;
  rot3_t t_r;
  logic signed [63:0] t_p [3];
  logic signed [65:0] dsum;
  logic [65:0] dm;
  logic signed [65:0] tr;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_v <= 1'b0;
    end else begin
      t_v <= q_v;
    end
    t_ok <= q_ok;
    t_idx <= cnt;
    t_r <= rw[cnt];
    t_p[0] <= rw[cnt].x * q_e[0];
    t_p[1] <= rw[cnt].y * q_e[1];
    t_p[2] <= rw[cnt].z * q_e[2];
  end

  always_comb begin
    dsum = 66'(t_p[0]) + 66'(t_p[1]) + 66'(t_p[2]);
    dm = dsum[65] ? 66'(-dsum) : 66'(dsum);
    dm = (dm + (66'd1 << (TR_SHIFT - 1))) >> TR_SHIFT;
    tr = dsum[65] ? $signed(dm) : -$signed(dm);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= t_v;
    end
    row_index <= t_idx;
    last_row <= (t_idx == ROW_LOOK);
    degenerate <= !t_ok;
    col_x <= t_ok ? t_r.x : 32'sd0;
    col_y <= t_ok ? t_r.y : 32'sd0;
    col_z <= t_ok ? t_r.z : 32'sd0;
    if (!t_ok) begin
      translation <= 32'sd0;
    end else if (tr > 66'sd2147483647) begin
      translation <= 32'h7fff_ffff;
    end else if (tr < -66'sd2147483648) begin
      translation <= 32'h8000_0000;
    end else begin
      translation <= tr[31:0];
    end
  end

  a_rows_three: assert property (@(posedge clk) disable iff (rst)
    cv |=> q_v && cnt == ROW_RIGHT)
    else $error("row sequence did not restart");
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    strobe |-> last_row == (row_index == ROW_LOOK))
    else $error("last row flag mismatch");
endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// Look-at view matrix testbench
// Drives eye, target and up requests through the start/busy handshake, with
// random idle bursts, and checks every strobed row field by field against a
// fixed-point view matrix predictor, or against fixed expected rows for the
// identity and degenerate cases. A short directed table covers the identity
// camera, degenerate cameras and extreme coordinates; random requests follow.
// ----------------------------------------------------------------------------
module tb_top;
  import lav_pkg::*;

  localparam longint ONE_ROT = 64'sd1 << ROT_FRAC;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_REQS = 270;
  localparam int FLAT_OUT_REQS = 40;
  localparam int DRAIN_CYCLES = 250;

  typedef longint vec3_t[3];

  typedef struct {
    coord_t ex, ey, ez, tx, ty, tz, ux, uy, uz;
  } view_req_t;

  typedef struct {
    logic [1:0] row;
    logic signed [31:0] cx, cy, cz, tr;
    logic last, degen;
  } view_row_t;

  typedef enum int {CHK_PREDICT, CHK_DEGEN, CHK_IDENTITY} check_kind_e;

  typedef struct {
    view_req_t req;
    check_kind_e kind;
  } stim_row_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  coord_t eye_x = 0, eye_y = 0, eye_z = 0;
  coord_t target_x = 0, target_y = 0, target_z = 0;
  coord_t up_x = 0, up_y = 0, up_z = 0;
  logic strobe;
  logic [1:0] row_index;
  logic signed [31:0] col_x, col_y, col_z, translation;
  logic last_row, degenerate;

  view_row_t pending_rows[$];
  stim_row_t stim_rows[$];
  int errors = 0;
  int cycles = 0;

  look_at_view_matrix u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
    .target_x(target_x), .target_y(target_y), .target_z(target_z),
    .up_x(up_x), .up_y(up_y), .up_z(up_z),
    .strobe(strobe), .row_index(row_index), .col_x(col_x), .col_y(col_y),
    .col_z(col_z), .translation(translation), .last_row(last_row),
    .degenerate(degenerate)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit unit_vec(input vec3_t v, output vec3_t u);
    longint unsigned a[3];
    longint unsigned mx, ss, nrm, q;
    mx = 0;
    ss = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = (v[i] < 0) ? longint'(-v[i]) : v[i];
      if (a[i] > mx) mx = a[i];
    end
    if (mx == 0) return 0;
    while (mx >= 64'h8000_0000) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
    end
    while (mx < 64'h4000_0000) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
    end
    for (int i = 0; i < 3; i++) ss = ss + a[i] * a[i];
    nrm = int_sqrt(ss);
    if (nrm == 0) return 0;
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << ROT_FRAC) + (nrm >> 1)) / nrm;
      if (q > ONE_ROT) q = ONE_ROT;
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic void cross_prod(input vec3_t a, input vec3_t b, output vec3_t c);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic longint round_q30(longint x);
    longint unsigned m;
    m = (x < 0) ? longint'(-x) : x;
    m = (m + (64'd1 << (ROT_FRAC - 1))) >> ROT_FRAC;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  task automatic predict_view_rows(input view_req_t r);
    vec3_t eye, look, upv, lu, uu, rv, ru, pu;
    longint rows[3][3];
    longint dot, tr, t;
    bit ok;
    view_row_t o;
    eye = '{longint'(r.ex), longint'(r.ey), longint'(r.ez)};
    look = '{longint'(r.tx) - eye[0], longint'(r.ty) - eye[1], longint'(r.tz) - eye[2]};
    upv = '{longint'(r.ux), longint'(r.uy), longint'(r.uz)};
    ok = unit_vec(look, lu);
    if (ok) ok = unit_vec(upv, uu);
    if (ok) begin
      cross_prod(lu, uu, rv);
      ok = unit_vec(rv, ru);
    end
    if (ok) begin
      cross_prod(ru, lu, pu);
      for (int i = 0; i < 3; i++) begin
        t = round_q30(pu[i]);
        if (t > ONE_ROT) t = ONE_ROT;
        if (t < -ONE_ROT) t = -ONE_ROT;
        rows[0][i] = ru[i];
        rows[1][i] = t;
        rows[2][i] = -lu[i];
      end
    end
    for (int k = 0; k < 3; k++) begin
      o.row = k[1:0];
      o.last = (k == 2);
      o.degen = !ok;
      o.cx = 0;
      o.cy = 0;
      o.cz = 0;
      o.tr = 0;
      if (ok) begin
        dot = 0;
        for (int i = 0; i < 3; i++) dot = dot + rows[k][i] * eye[i];
        tr = -round_q30(dot);
        if (tr > 64'sh7FFF_FFFF) tr = 64'sh7FFF_FFFF;
        if (tr < -64'sh8000_0000) tr = -64'sh8000_0000;
        o.cx = rows[k][0][31:0];
        o.cy = rows[k][1][31:0];
        o.cz = rows[k][2][31:0];
        o.tr = tr[31:0];
      end
      pending_rows.push_back(o);
    end
  endtask

  task automatic push_fixed_rows(input check_kind_e kind);
    view_row_t o;
    for (int k = 0; k < 3; k++) begin
      o.row = k[1:0];
      o.last = (k == 2);
      o.degen = (kind == CHK_DEGEN);
      o.cx = (kind == CHK_IDENTITY && k == 0) ? 32'sh4000_0000 : 0;
      o.cy = (kind == CHK_IDENTITY && k == 1) ? 32'sh4000_0000 : 0;
      o.cz = (kind == CHK_IDENTITY && k == 2) ? 32'sh4000_0000 : 0;
      o.tr = 0;
      pending_rows.push_back(o);
    end
  endtask

  task automatic report(input string field, input longint got, input longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    view_row_t w;
    if (!rst && strobe) begin
      if (pending_rows.size() == 0) begin
        report("unexpected row", row_index, -1);
      end else begin
        w = pending_rows.pop_front();
        if (row_index !== w.row) report("row_index", row_index, w.row);
        if (col_x !== w.cx) report("col_x", col_x, w.cx);
        if (col_y !== w.cy) report("col_y", col_y, w.cy);
        if (col_z !== w.cz) report("col_z", col_z, w.cz);
        if (translation !== w.tr) report("translation", translation, w.tr);
        if (last_row !== w.last) report("last_row", last_row, w.last);
        if (degenerate !== w.degen) report("degenerate", degenerate, w.degen);
      end
    end
  end

  task automatic send_request(input view_req_t r, input check_kind_e kind);
    eye_x <= r.ex; eye_y <= r.ey; eye_z <= r.ez;
    target_x <= r.tx; target_y <= r.ty; target_z <= r.tz;
    up_x <= r.ux; up_y <= r.uy; up_z <= r.uz;
    start <= 1;
    do @(posedge clk); while (busy);
    if (kind == CHK_PREDICT) predict_view_rows(r);
    else push_fixed_rows(kind);
  endtask

  task automatic maybe_idle(input bit allowed);
    if (allowed && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic add_stim(input check_kind_e kind, input coord_t ex, ey, ez,
                          input coord_t tx, ty, tz, input coord_t ux, uy, uz);
    stim_row_t s;
    s.kind = kind;
    s.req = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
    stim_rows.push_back(s);
  endtask

  function automatic coord_t rand_coord(input int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
      2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 64)) - 32;
    endcase
  endfunction

  function automatic view_req_t random_request();
    view_req_t r;
    int mode, shape;
    mode = $urandom_range(0, 3);
    r.ex = rand_coord(mode); r.ey = rand_coord(mode); r.ez = rand_coord(mode);
    r.tx = rand_coord(mode); r.ty = rand_coord(mode); r.tz = rand_coord(mode);
    r.ux = rand_coord($urandom_range(0, 3));
    r.uy = rand_coord($urandom_range(0, 3));
    r.uz = rand_coord($urandom_range(0, 3));
    shape = $urandom_range(0, 19);
    if (shape == 0) begin
      r.tx = r.ex; r.ty = r.ey; r.tz = r.ez;
    end else if (shape == 1) begin
      r.ux = 0; r.uy = 0; r.uz = 0;
    end else if (shape == 2) begin
      r.ex = 0; r.ey = 0; r.ez = 0;
      r.tx = rand_coord(1); r.ty = rand_coord(1); r.tz = rand_coord(1);
      r.ux = r.tx * 3; r.uy = r.ty * 3; r.uz = r.tz * 3;
    end
    return r;
  endfunction

  initial begin
    view_req_t r;
    add_stim(CHK_IDENTITY, 0, 0, 0, 0, 0, -32'sh1_0000, 0, 32'sh1_0000, 0);
    add_stim(CHK_DEGEN, 32'sh1_0000, 2, -3, 32'sh1_0000, 2, -3, 0, 32'sh1_0000, 0);
    add_stim(CHK_DEGEN, 0, 0, 0, 5, 6, 7, 0, 0, 0);
    add_stim(CHK_DEGEN, 0, 0, 0, 0, 0, -32'sh1_0000, 0, 0, 32'sh7FFF_FFFF);
    add_stim(CHK_DEGEN, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
             32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
             32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    add_stim(CHK_PREDICT, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
             32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
             32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    add_stim(CHK_PREDICT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
             32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
             32'sh8000_0000, 32'sh7FFF_FFFF, 0);
    add_stim(CHK_PREDICT, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
             32'sh7FFF_FFFE, 32'sh8000_0001, 32'sh7FFF_FFFF, 0, 0, 1);
    add_stim(CHK_PREDICT, 0, 0, 0, 1, 0, 0, 0, 1, 0);
    add_stim(CHK_PREDICT, 0, 0, 0, 1, 1, 1, 0, 0, -1);
    add_stim(CHK_PREDICT, 32'sh0003_0000, 32'sh0002_0000, 32'sh0001_0000,
             0, 0, 0, 0, 32'sh0001_0000, 0);
    add_stim(CHK_PREDICT, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
             32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
             32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
    add_stim(CHK_PREDICT, -1, -1, -1, 32'sh1234_5678, 32'shEDCB_A987, 32'sh0F0F_0F0F,
             32'shFFFF_FFFF, 32'sh0000_0001, 32'sh5555_5555);

    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      send_request(stim_rows[i].req, stim_rows[i].kind);
      maybe_idle(1);
    end

    start <= 0;
    while (pending_rows.size() != 0) @(posedge clk);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      r = random_request();
      send_request(r, CHK_PREDICT);
      maybe_idle(n < RANDOM_REQS - FLAT_OUT_REQS);
    end
    start <= 0;

    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
